/* design/stslf_pkg.sv */
// Shared types, constants and the sine table generator for the sine tone synthesizer.
// Used by the configuration channel interface and by every module of the block.
package stslf_pkg;

  localparam int unsigned ChunkSamplesDefault  = 128;
  localparam int unsigned SineTableBitsDefault = 10;
  localparam int unsigned QueueDepth           = 4;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] RegVolumePercent = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMuted         = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPhaseStep     = 2'd2;
  localparam logic [CfgIdxW-1:0] RegLevelThr      = 2'd3;

  localparam logic [6:0]  VolumePercentReset = 7'd80;
  localparam logic [31:0] PhaseStepReset     = 32'd24932236;
  localparam logic [31:0] LevelThrReset      = 32'd1315334;

  localparam int unsigned AmpW  = 15;
  localparam int unsigned MagW  = 15;
  localparam int unsigned DiffW = 42;

  localparam logic [AmpW-1:0] FullAmp       = 15'd24575;
  localparam logic [15:0]     FullScaleProd = 16'd25600;
  // Reciprocal of 25 scaled by 2^20, rounded down.
  localparam logic [15:0]     AmpRecip      = 16'd41943;
  localparam logic [4:0]      AmpDiv        = 5'd25;
  localparam logic [MagW-1:0] SineMax       = 15'd32767;

  localparam longint unsigned TwoPiQ30 = 64'd6746518852;

  typedef struct packed {
    logic [6:0]  volume_percent;
    logic        muted;
    logic [31:0] phase_step_per_hz;
    logic [31:0] level_threshold_sq;
  } cfg_t;

  typedef struct packed {
    logic            silent;
    logic            last;
    logic [31:0]     inc;
    logic [AmpW-1:0] amp;
  } item_t;

  // First-quadrant sine of entry j, Q30 Taylor series rounded to 0..32767.
  function automatic logic [MagW-1:0] quarter_sine(int unsigned j, int unsigned table_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned r;
    longint          acc;
    x   = (64'(j) * TwoPiQ30) >> table_bits;
    x2  = (x * x) >> 30;
    t   = x;
    acc = signed'(x);
    for (int n = 1; n <= 8; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        acc = acc - signed'(t);
      end else begin
        acc = acc + signed'(t);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    r = (unsigned'(acc) * 64'(SineMax) + (64'd1 << 29)) >> 30;
    if (r > 64'(SineMax)) begin
      r = 64'(SineMax);
    end
    return r[MagW-1:0];
  endfunction

endpackage

/* design/stslf_if.sv */
// Valid/ready channel interfaces of the sine tone synthesizer: requests, results
// and configuration writes. Depends on stslf_pkg.
interface stslf_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] freq_hz;
  logic [8:0]  volume_scale;
  logic        last_in_chunk;

  modport source (output valid, freq_hz, volume_scale, last_in_chunk, input ready);
  modport sink (input valid, freq_hz, volume_scale, last_in_chunk, output ready);
endinterface

interface stslf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               chunk_done;
  logic               level_open;
  logic               level_changed;

  modport source (output valid, sample, chunk_done, level_open, level_changed, input ready);
  modport sink (input valid, sample, chunk_done, level_open, level_changed, output ready);
endinterface

interface stslf_cfg_if;
  import stslf_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/stslf_front.sv */
// Front end: accepts sample requests, computes the phase increment and the amplitude.
// Depends on stslf_pkg and stslf_in_if.
module stslf_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  stslf_in_if.sink         req_i,
  input  stslf_pkg::cfg_t  cfg_i,
  output stslf_pkg::item_t push_item_o,
  output logic             push_valid_o,
  input  logic             push_ready_i
);
  import stslf_pkg::*;

  logic adv;

  logic        s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic [15:0] s1_prod_q;
  logic [31:0] s1_inc_q, s2_inc_q, s3_inc_q;
  logic        s1_silent_q, s2_silent_q, s3_silent_q;
  logic        s1_last_q, s2_last_q, s3_last_q;
  logic        s1_sat_q, s2_sat_q, s3_sat_q;
  logic [19:0] s2_m_q, s3_m_q;
  logic [AmpW-1:0] s3_q0_q;
  item_t       s4_item_q;

  logic [47:0] inc_full;
  logic [15:0] prod;
  logic [29:0] scaled;
  logic [35:0] recip_prod;
  logic [19:0] rem;
  logic [AmpW-1:0] amp_calc;

  assign adv          = !s4_valid_q || push_ready_i;
  assign req_i.ready  = adv;
  assign push_valid_o = s4_valid_q;
  assign push_item_o  = s4_item_q;

  assign inc_full   = 48'(req_i.freq_hz) * 48'(cfg_i.phase_step_per_hz);
  assign prod       = 16'(cfg_i.volume_percent) * 16'(req_i.volume_scale);
  assign scaled     = 30'(s1_prod_q) * 30'(FullAmp);
  assign recip_prod = 36'(s2_m_q) * 36'(AmpRecip);
  assign rem        = s3_m_q - (20'(s3_q0_q) * 20'(AmpDiv));
  assign amp_calc   = s3_q0_q + AmpW'(rem >= 20'(AmpDiv));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= req_i.valid;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_prod_q   <= prod;
      s1_inc_q    <= inc_full[39:8];
      s1_silent_q <= cfg_i.muted || (cfg_i.volume_percent == '0);
      s1_last_q   <= req_i.last_in_chunk;
      s1_sat_q    <= prod >= FullScaleProd;

      s2_m_q      <= scaled[29:10];
      s2_inc_q    <= s1_inc_q;
      s2_silent_q <= s1_silent_q;
      s2_last_q   <= s1_last_q;
      s2_sat_q    <= s1_sat_q;

      s3_q0_q     <= recip_prod[34:20];
      s3_m_q      <= s2_m_q;
      s3_inc_q    <= s2_inc_q;
      s3_silent_q <= s2_silent_q;
      s3_last_q   <= s2_last_q;
      s3_sat_q    <= s2_sat_q;

      s4_item_q.silent <= s3_silent_q;
      s4_item_q.last   <= s3_last_q;
      s4_item_q.inc    <= s3_inc_q;
      s4_item_q.amp    <= s3_silent_q ? '0 : (s3_sat_q ? FullAmp : amp_calc);
    end
  end

endmodule

/* design/stslf_queue.sv */
// Short item queue between the front end and the back end.
// Depends on stslf_pkg.
module stslf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stslf_pkg::item_t push_item_i,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  output stslf_pkg::item_t pop_item_o,
  output logic             pop_valid_o,
  input  logic             pop_ready_i
);
  import stslf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  item_t            mem_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("queue fill count above depth");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill count did not follow a push");

endmodule

/* design/stslf_back.sv */
// Back end: phase accumulator, quarter-wave sine table, sample scaling and the
// chunk level detector. Depends on stslf_pkg and stslf_out_if.
module stslf_back #(
  parameter int unsigned CHUNK_SAMPLES   = stslf_pkg::ChunkSamplesDefault,
  parameter int unsigned SINE_TABLE_BITS = stslf_pkg::SineTableBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stslf_pkg::item_t pop_item_i,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  logic [31:0]      level_threshold_sq_i,
  stslf_out_if.source      res_o
);
  import stslf_pkg::*;

  localparam int unsigned Qtr   = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned AddrW = SINE_TABLE_BITS - 1;
  localparam int unsigned RomW  = (Qtr + 1) * MagW;
  localparam int unsigned CntW  = $clog2(CHUNK_SAMPLES + 1);

  function automatic logic [RomW-1:0] build_rom();
    logic [RomW-1:0] r;
    r = '0;
    for (int k = 0; k <= Qtr; k++) begin
      r[k*MagW +: MagW] = quarter_sine(unsigned'(k), SINE_TABLE_BITS);
    end
    return r;
  endfunction

  localparam logic [RomW-1:0] SineRom = build_rom();

  logic adv;

  logic [31:0]                phase_q;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [AddrW-1:0]           addr;

  logic            b1_valid_q, b2_valid_q, b3_valid_q, b4_valid_q;
  logic [MagW-1:0] b1_mag_q;
  logic [AmpW-1:0] b1_amp_q;
  logic            b1_neg_q, b2_neg_q;
  logic            b1_silent_q, b2_silent_q, b3_silent_q, b4_silent_q;
  logic            b1_last_q, b2_last_q, b3_last_q, b4_last_q;
  logic [29:0]     b2_prod_q;
  logic signed [15:0] b3_sample_q, b4_sample_q;
  logic [AmpW-1:0] b3_quot_q;
  logic [29:0]     b4_sq_q;

  logic [AmpW-1:0] q0;
  logic [29:0]     rem;
  logic [AmpW-1:0] quot;

  logic [CntW-1:0]         cnt_q, cnt_inc;
  logic signed [DiffW-1:0] diff_q, diff_new;
  logic                    open_q;
  logic                    chunk_end, chunk_open, closes;

  logic               res_valid_q;
  logic signed [15:0] sample_q;
  logic               done_q, level_open_q, changed_q;

  assign adv         = !res_valid_q || res_o.ready;
  assign pop_ready_o = adv;

  assign idx  = phase_q[31 -: SINE_TABLE_BITS];
  assign addr = idx[SINE_TABLE_BITS-2] ?
                (AddrW'(Qtr) - AddrW'(idx[SINE_TABLE_BITS-3:0])) :
                AddrW'(idx[SINE_TABLE_BITS-3:0]);

  // Division by 32767: the shift estimate is at most one low.
  assign q0   = b2_prod_q[29:15];
  assign rem  = b2_prod_q - (30'(q0) << 15) + 30'(q0);
  assign quot = q0 + AmpW'(rem >= 30'(SineMax));

  assign cnt_inc    = cnt_q + 1'b1;
  assign chunk_end  = b4_last_q || (cnt_inc == CntW'(CHUNK_SAMPLES));
  assign diff_new   = diff_q + $signed(DiffW'(b4_sq_q)) - $signed(DiffW'(level_threshold_sq_i));
  assign chunk_open = !diff_new[DiffW-1];
  assign closes     = !b4_silent_q && chunk_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      b3_valid_q  <= 1'b0;
      b4_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      cnt_q       <= '0;
      diff_q      <= '0;
      open_q      <= 1'b0;
    end else if (adv) begin
      b1_valid_q  <= pop_valid_i;
      b2_valid_q  <= b1_valid_q;
      b3_valid_q  <= b2_valid_q;
      b4_valid_q  <= b3_valid_q;
      res_valid_q <= b4_valid_q;
      if (pop_valid_i && !pop_item_i.silent) begin
        phase_q <= phase_q + pop_item_i.inc;
      end
      if (b4_valid_q && !b4_silent_q) begin
        if (chunk_end) begin
          open_q <= chunk_open;
          cnt_q  <= '0;
          diff_q <= '0;
        end else begin
          cnt_q  <= cnt_inc;
          diff_q <= diff_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      b1_mag_q    <= SineRom[addr*MagW +: MagW];
      b1_neg_q    <= idx[SINE_TABLE_BITS-1];
      b1_amp_q    <= pop_item_i.amp;
      b1_silent_q <= pop_item_i.silent;
      b1_last_q   <= pop_item_i.last;

      b2_prod_q   <= 30'(b1_mag_q) * 30'(b1_amp_q);
      b2_neg_q    <= b1_neg_q;
      b2_silent_q <= b1_silent_q;
      b2_last_q   <= b1_last_q;

      b3_quot_q   <= quot;
      b3_sample_q <= b2_neg_q ? -$signed(16'(quot)) : $signed(16'(quot));
      b3_silent_q <= b2_silent_q;
      b3_last_q   <= b2_last_q;

      b4_sq_q     <= 30'(b3_quot_q) * 30'(b3_quot_q);
      b4_sample_q <= b3_sample_q;
      b4_silent_q <= b3_silent_q;
      b4_last_q   <= b3_last_q;

      sample_q     <= b4_sample_q;
      done_q       <= closes;
      level_open_q <= closes ? chunk_open : open_q;
      changed_q    <= closes && (chunk_open != open_q);
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.sample        = sample_q;
  assign res_o.chunk_done    = done_q;
  assign res_o.level_open    = level_open_q;
  assign res_o.level_changed = changed_q;

  a_cnt_below_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CntW'(CHUNK_SAMPLES))
    else $error("chunk counter reached the chunk length without closing");

  a_chunk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && b4_valid_q && closes) |=> (cnt_q == '0 && diff_q == '0))
    else $error("chunk state not cleared after a chunk end");

  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv && pop_valid_i && !pop_item_i.silent) |=> $stable(phase_q))
    else $error("phase moved without a sounding item");

  a_change_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.level_changed) |-> res_o.chunk_done)
    else $error("level change reported outside a chunk end");

endmodule

/* design/sine_tone_synth_with_level_flag.sv */
// Top level of the sine tone synthesizer with chunk level flag: configuration
// registers, front end, item queue and back end. Depends on stslf_pkg and stslf_if.
//
// Each accepted request yields one sample item, in order. The block sustains
// one item per clock while the result side does not stall: the phase
// accumulator add and the level difference add are not pipelined, and the
// four-entry queue lets the request side keep going while a result waits.
// Muted requests or a zero master volume give zero samples and leave the phase and
// the level detector untouched. Configuration writes are taken at any time with
// ready held high, and are meant to be made while no request is in flight.
module sine_tone_synth_with_level_flag #(
  parameter int unsigned CHUNK_SAMPLES   = stslf_pkg::ChunkSamplesDefault,
  parameter int unsigned SINE_TABLE_BITS = stslf_pkg::SineTableBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stslf_in_if.sink     req_i,
  stslf_out_if.source  res_o,
  stslf_cfg_if.sink    cfg_i
);
  import stslf_pkg::*;

  cfg_t  cfg_q;
  item_t push_item, pop_item;
  logic  push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.volume_percent     <= VolumePercentReset;
      cfg_q.muted              <= 1'b0;
      cfg_q.phase_step_per_hz  <= PhaseStepReset;
      cfg_q.level_threshold_sq <= LevelThrReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegVolumePercent: cfg_q.volume_percent     <= cfg_i.data[6:0];
        RegMuted:         cfg_q.muted              <= cfg_i.data[0];
        RegPhaseStep:     cfg_q.phase_step_per_hz  <= cfg_i.data;
        RegLevelThr:      cfg_q.level_threshold_sq <= cfg_i.data;
      endcase
    end
  end

  stslf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cfg_i        (cfg_q),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  stslf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  stslf_back #(
    .CHUNK_SAMPLES   (CHUNK_SAMPLES),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .pop_item_i           (pop_item),
    .pop_valid_i          (pop_valid),
    .pop_ready_o          (pop_ready),
    .level_threshold_sq_i (cfg_q.level_threshold_sq),
    .res_o                (res_o)
  );

endmodule
